// ----- rtl/hgpc_pkg.sv -----
`timescale 1ns / 1ps

package hgpc_pkg;

  // Width of the two area registers.
  localparam int REG_W = 13;

  // Default sizes handed to the top level.
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  // Reset values of the area registers.
  localparam logic [REG_W-1:0] AREA_WIDTH_RST  = 13'd256;
  localparam logic [REG_W-1:0] AREA_HEIGHT_RST = 13'd256;

  // APB port sizes.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register index, taken from the word address bit.
  typedef enum logic {
    REG_AREA_WIDTH  = 1'b0,
    REG_AREA_HEIGHT = 1'b1
  } reg_idx_e;

  // Lanes of the shared fraction divider.
  localparam int NUM_LANES = 3;
  localparam int LANE_HUE  = 0;
  localparam int LANE_SAT  = 1;
  localparam int LANE_VAL  = 2;

  // One sixth of the hue circle each.
  typedef enum logic [2:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5
  } sector_e;

endpackage

// ----- rtl/hsv_gradient_pixel_color.sv -----
`timescale 1ns / 1ps

// Channel   | Direction | Signals                             | Handshake
// ----------+-----------+-------------------------------------+---------------------------
// pixel in  | input     | x_coord_i, y_coord_i                | start && !busy
// color out | output    | red_o, green_o, blue_o              | done_o, one cycle
// config    | APB       | psel, penable, pwrite, paddr, pwdata| psel & penable & pwrite
//
// One pixel word is accepted every clock; busy stays low.
// From accept to done_o, the modulo by width takes one stage per coordinate bit
// and the fraction divider one stage per quotient bit, followed by three
// multiply stages and the output.
// Reset clears the valid bits and loads 256 into both area registers.
// There is no back pressure; every result is shown for exactly one cycle.
module hsv_gradient_pixel_color
  import hgpc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] x_coord_i,
  input  logic [COORD_BITS-1:0] y_coord_i,
  output logic                  done_o,
  output logic [7:0]            red_o,
  output logic [7:0]            green_o,
  output logic [7:0]            blue_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int DW  = (COORD_BITS + 1 > REG_W) ? COORD_BITS + 1 : REG_W;
  localparam int F1  = FRAC_BITS + 1;
  localparam int LAT = COORD_BITS + FRAC_BITS + 5;
  localparam logic [F1-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [DW-1:0] DW_ONE = {{(DW-1){1'b0}}, 1'b1};

  // Configuration registers.
  logic [REG_W-1:0] area_width_q;
  logic [REG_W-1:0] area_height_q;
  logic             cfg_wr;
  reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[APB_ADDR_W-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_width_q  <= AREA_WIDTH_RST;
      area_height_q <= AREA_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_AREA_WIDTH:  area_width_q  <= pwdata[REG_W-1:0];
        REG_AREA_HEIGHT: area_height_q <= pwdata[REG_W-1:0];
        default:         area_width_q  <= area_width_q;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (cfg_idx)
      REG_AREA_WIDTH:  prdata = {{(APB_DATA_W-REG_W){1'b0}}, area_width_q};
      REG_AREA_HEIGHT: prdata = {{(APB_DATA_W-REG_W){1'b0}}, area_height_q};
      default:         prdata = '0;
    endcase
  end

  // The pipeline never stalls.
  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // x modulo width: one bit of x per stage, MSB of x first.
  logic [COORD_BITS-1:0] mv_q;
  logic [REG_W-1:0]      mr_q [COORD_BITS];
  logic [COORD_BITS-1:0] mx_q [COORD_BITS];
  logic [COORD_BITS-1:0] my_q [COORD_BITS];

  for (genvar k = 0; k < COORD_BITS; k++) begin : g_mod
    logic [REG_W-1:0]      rem_in;
    logic [COORD_BITS-1:0] x_in;
    logic [COORD_BITS-1:0] y_in;
    logic                  v_in;
    logic [REG_W:0]        sh;
    logic [REG_W:0]        diff;
    logic [REG_W-1:0]      rem_d;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign x_in   = x_coord_i;
      assign y_in   = y_coord_i;
      assign v_in   = accept;
    end else begin : g_next
      assign rem_in = mr_q[k-1];
      assign x_in   = mx_q[k-1];
      assign y_in   = my_q[k-1];
      assign v_in   = mv_q[k-1];
    end

    always_comb begin
      sh    = {rem_in, x_in[COORD_BITS-1]};
      diff  = sh - {1'b0, area_width_q};
      rem_d = (sh >= {1'b0, area_width_q}) ? diff[REG_W-1:0] : sh[REG_W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_q[k] <= 1'b0;
      end else begin
        mv_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      mr_q[k] <= rem_d;
      mx_q[k] <= x_in << 1;
      my_q[k] <= y_in;
    end
  end

  // Operands of hue, saturation and value fractions.
  logic [NUM_LANES-1:0][DW-1:0] num;
  logic [NUM_LANES-1:0][DW-1:0] den;
  logic                         neg_v;
  logic [DW-1:0]                half;
  logic [DW-1:0]                two_half;
  logic [DW-1:0]                y_ext;
  logic [DW-1:0]                w_ext;
  logic [DW-1:0]                r_ext;

  always_comb begin
    half     = DW'(area_height_q[REG_W-1:1]);
    two_half = DW'({area_height_q[REG_W-1:1], 1'b0});
    y_ext    = DW'(my_q[COORD_BITS-1]);
    w_ext    = DW'(area_width_q);
    r_ext    = DW'(mr_q[COORD_BITS-1]);
    neg_v    = 1'b0;

    // Zero width gives hue zero.
    if (area_width_q == '0) begin
      num[LANE_HUE] = '0;
      den[LANE_HUE] = DW_ONE;
    end else begin
      num[LANE_HUE] = r_ext;
      den[LANE_HUE] = w_ext;
    end

    if (y_ext <= half) begin
      // Upper half: full value, saturation rises with y.
      if (half == '0) begin
        num[LANE_SAT] = '0;
        den[LANE_SAT] = DW_ONE;
      end else begin
        num[LANE_SAT] = y_ext;
        den[LANE_SAT] = half;
      end
      num[LANE_VAL] = DW_ONE;
      den[LANE_VAL] = DW_ONE;
    end else begin
      // Lower half: value falls and may go negative.
      num[LANE_SAT] = half;
      den[LANE_SAT] = y_ext;
      den[LANE_VAL] = y_ext;
      if (two_half >= y_ext) begin
        num[LANE_VAL] = two_half - y_ext;
      end else begin
        num[LANE_VAL] = y_ext - two_half;
        neg_v         = 1'b1;
      end
    end
  end

  logic                         dv;
  logic [NUM_LANES-1:0][F1-1:0] dq;
  logic                         dneg;

  hgpc_fdiv #(
    .DW        (DW),
    .FRAC_BITS (FRAC_BITS),
    .LANES     (NUM_LANES),
    .TAG_W     (1)
  ) u_fdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mv_q[COORD_BITS-1]),
    .num_i   (num),
    .den_i   (den),
    .tag_i   (neg_v),
    .valid_o (dv),
    .quo_o   (dq),
    .tag_o   (dneg)
  );

  // Stage 1: sector and fraction from hue times six.
  logic                 p1_v_q;
  sector_e              p1_sec_q;
  logic [FRAC_BITS-1:0] p1_f_q;
  logic [F1-1:0]        p1_omf_q, p1_s_q, p1_oms_q, p1_vm_q;
  logic                 p1_neg_q;
  logic [FRAC_BITS+2:0] h6;

  assign h6 = {dq[LANE_HUE][FRAC_BITS-1:0], 2'b00}
            + {1'b0, dq[LANE_HUE][FRAC_BITS-1:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else begin
      p1_v_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_sec_q <= sector_e'(h6[FRAC_BITS+2:FRAC_BITS]);
    p1_f_q   <= h6[FRAC_BITS-1:0];
    p1_omf_q <= ONE - {1'b0, h6[FRAC_BITS-1:0]};
    p1_s_q   <= dq[LANE_SAT];
    p1_oms_q <= ONE - dq[LANE_SAT];
    p1_vm_q  <= dq[LANE_VAL];
    p1_neg_q <= dneg;
  end

  // Stage 2: s*f, s*(1-f) and the p term.
  logic          p2_v_q;
  sector_e       p2_sec_q;
  logic [F1-1:0] p2_sf_q, p2_sof_q, p2_pm_q, p2_vm_q;
  logic          p2_neg_q;
  logic [2*F1-1:0] m_sf, m_sof, m_p;

  assign m_sf  = p1_s_q * {1'b0, p1_f_q};
  assign m_sof = p1_s_q * p1_omf_q;
  assign m_p   = p1_vm_q * p1_oms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else begin
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_sec_q <= p1_sec_q;
    p2_sf_q  <= m_sf[2*FRAC_BITS:FRAC_BITS];
    p2_sof_q <= m_sof[2*FRAC_BITS:FRAC_BITS];
    p2_pm_q  <= m_p[2*FRAC_BITS:FRAC_BITS];
    p2_vm_q  <= p1_vm_q;
    p2_neg_q <= p1_neg_q;
  end

  // Stage 3: q and t terms.
  logic          p3_v_q;
  sector_e       p3_sec_q;
  logic [F1-1:0] p3_qm_q, p3_tm_q, p3_pm_q, p3_vm_q;
  logic          p3_neg_q;
  logic [2*F1-1:0] m_q, m_t;

  assign m_q = p2_vm_q * (ONE - p2_sf_q);
  assign m_t = p2_vm_q * (ONE - p2_sof_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_v_q <= 1'b0;
    end else begin
      p3_v_q <= p2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p3_sec_q <= p2_sec_q;
    p3_qm_q  <= m_q[2*FRAC_BITS:FRAC_BITS];
    p3_tm_q  <= m_t[2*FRAC_BITS:FRAC_BITS];
    p3_pm_q  <= p2_pm_q;
    p3_vm_q  <= p2_vm_q;
    p3_neg_q <= p2_neg_q;
  end

  // Scale a term magnitude by 255, clamp, and zero it when negative.
  function automatic logic [7:0] to_chan(input logic [F1-1:0] mag, input logic neg);
    logic [F1+7:0] sc;
    logic [8:0]    c;
    sc = {mag, 8'b0} - {8'b0, mag};
    c  = sc[FRAC_BITS+8:FRAC_BITS];
    if (neg) begin
      return 8'd0;
    end else if (c[8]) begin
      return 8'd255;
    end else begin
      return c[7:0];
    end
  endfunction

  // Stage 4: sector routing and output register.
  logic [F1-1:0] r_m, g_m, b_m;

  always_comb begin
    unique case (p3_sec_q)
      SEC_R_TO_Y: begin r_m = p3_vm_q; g_m = p3_tm_q; b_m = p3_pm_q; end
      SEC_Y_TO_G: begin r_m = p3_qm_q; g_m = p3_vm_q; b_m = p3_pm_q; end
      SEC_G_TO_C: begin r_m = p3_pm_q; g_m = p3_vm_q; b_m = p3_tm_q; end
      SEC_C_TO_B: begin r_m = p3_pm_q; g_m = p3_qm_q; b_m = p3_vm_q; end
      SEC_B_TO_M: begin r_m = p3_tm_q; g_m = p3_pm_q; b_m = p3_vm_q; end
      default:    begin r_m = p3_vm_q; g_m = p3_pm_q; b_m = p3_qm_q; end
    endcase
  end

  logic       done_q;
  logic [7:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= p3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= to_chan(r_m, p3_neg_q);
    green_q <= to_chan(g_m, p3_neg_q);
    blue_q  <= to_chan(b_m, p3_neg_q);
  end

  assign done_o  = done_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

  // Every accepted pixel comes out after the fixed latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("pixel result missing after pipeline latency");

  // Divider fractions stay within one, hue strictly below.
  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv |-> (dq[LANE_SAT] <= ONE) && (dq[LANE_HUE] < ONE) && (dq[LANE_VAL] <= ONE))
    else $error("divider fraction out of range");

  // The p, q and t terms never exceed the value magnitude.
  a_term_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p3_v_q |-> (p3_qm_q <= p3_vm_q) && (p3_tm_q <= p3_vm_q) && (p3_pm_q <= p3_vm_q))
    else $error("color term above value");

  // A strobe only follows a valid last stage.
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(p3_v_q))
    else $error("result strobe without valid pipeline word");

endmodule

// ----- rtl/hgpc_fdiv.sv -----
`timescale 1ns / 1ps

// Pipelined restoring divider for fractions num/den with num <= den.
// Each lane gives floor(num * 2^FRAC_BITS / den) in FRAC_BITS+1 bits,
// one quotient bit per register stage.
module hgpc_fdiv #(
  parameter int DW        = 13,
  parameter int FRAC_BITS = 16,
  parameter int LANES     = 3,
  parameter int TAG_W     = 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic [LANES-1:0][DW-1:0]            num_i,
  input  logic [LANES-1:0][DW-1:0]            den_i,
  input  logic [TAG_W-1:0]                    tag_i,
  output logic                                valid_o,
  output logic [LANES-1:0][FRAC_BITS:0]       quo_o,
  output logic [TAG_W-1:0]                    tag_o
);

  localparam int STAGES = FRAC_BITS + 1;

  logic [STAGES-1:0]                  v_q;
  logic [LANES-1:0][DW-1:0]           rem_q [STAGES];
  logic [LANES-1:0][DW-1:0]           den_q [STAGES];
  logic [LANES-1:0][FRAC_BITS:0]      quo_q [STAGES];
  logic [TAG_W-1:0]                   tag_q [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [LANES-1:0][DW-1:0]      rem_d;
    logic [LANES-1:0][FRAC_BITS:0] quo_d;
    logic [LANES-1:0][DW-1:0]      den_in;
    logic [TAG_W-1:0]              tag_in;
    logic                          v_in;

    if (k == 0) begin : g_first
      assign den_in = den_i;
      assign tag_in = tag_i;
      assign v_in   = valid_i;
    end else begin : g_next
      assign den_in = den_q[k-1];
      assign tag_in = tag_q[k-1];
      assign v_in   = v_q[k-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DW:0]          sh;
      logic [DW:0]          diff;
      logic                 ge;
      logic [FRAC_BITS-1:0] qprev;

      // The first stage decides the integer bit, the rest shift and subtract.
      if (k == 0) begin : g_first
        assign sh    = {1'b0, num_i[l]};
        assign qprev = '0;
      end else begin : g_next
        assign sh    = {rem_q[k-1][l], 1'b0};
        assign qprev = quo_q[k-1][l][FRAC_BITS-1:0];
      end

      always_comb begin
        diff = sh - {1'b0, den_in[l]};
        ge   = (sh >= {1'b0, den_in[l]});
        rem_d[l] = ge ? diff[DW-1:0] : sh[DW-1:0];
        quo_d[l] = {qprev, ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d;
      den_q[k] <= den_in;
      quo_q[k] <= quo_d;
      tag_q[k] <= tag_in;
    end
  end

  assign valid_o = v_q[STAGES-1];
  assign quo_o   = quo_q[STAGES-1];
  assign tag_o   = tag_q[STAGES-1];

endmodule
